FILE: design/gda_pkg.sv
package gda_pkg;

	// field widths
	localparam int unsigned DayW    = 5;
	localparam int unsigned MonW    = 4;
	localparam int unsigned InYearW = 14;
	localparam int unsigned AmtW    = 15;
	localparam int unsigned StatW   = 2;

	// working year: holds any year up to the largest limit plus one
	localparam int unsigned YearW   = 16;
	// quotient of the working year by 100, and the remainder
	localparam int unsigned CentW   = 9;
	localparam int unsigned RemW    = 7;
	// days left to add: amount times seven
	localparam int unsigned LeftW   = 18;
	// sum for year adds: year plus amount times ten
	localparam int unsigned YSumW   = 19;

	// reciprocal of 100 scaled by 2^19, exact for 14-bit years
	localparam int unsigned RecipShift = 19;
	localparam int unsigned RecipW     = 13;
	localparam logic [RecipW-1:0] Recip100 = 13'd5243;
	localparam int unsigned ProdW      = InYearW + RecipW;

	localparam logic [MonW-1:0] MonDec = 4'd12;
	localparam logic [MonW-1:0] MonJan = 4'd1;
	localparam logic [MonW-1:0] MonFeb = 4'd2;
	localparam logic [RemW-1:0] RemTop = 7'd99;

	// operation codes
	localparam logic [1:0] FUNC_DAYS    = 2'd0;
	localparam logic [1:0] FUNC_WEEKS   = 2'd1;
	localparam logic [1:0] FUNC_YEARS   = 2'd2;
	localparam logic [1:0] FUNC_DECADES = 2'd3;

	// status codes
	localparam logic [StatW-1:0] ST_OK       = 2'd0;
	localparam logic [StatW-1:0] ST_INVALID  = 2'd1;
	localparam logic [StatW-1:0] ST_OVERFLOW = 2'd2;

	// sequencer program
	localparam int unsigned UpcW = 4;

	typedef enum logic [2:0] {
		ACT_NOP     = 3'd0,
		ACT_DIV     = 3'd1,
		ACT_REM     = 3'd2,
		ACT_MONTH   = 3'd3,
		ACT_YADD    = 3'd4,
		ACT_FIN_OK  = 3'd5,
		ACT_FIN_INV = 3'd6,
		ACT_FIN_OVF = 3'd7
	} act_t;

	typedef enum logic [2:0] {
		CND_NEVER     = 3'd0,
		CND_ALWAYS    = 3'd1,
		CND_NO_START  = 3'd2,
		CND_INVALID   = 3'd3,
		CND_YEAR_OP   = 3'd4,
		CND_LOOP_EXIT = 3'd5,
		CND_OVER      = 3'd6,
		CND_YSUM_OVER = 3'd7
	} cnd_t;

	typedef struct packed {
		act_t            act;
		cnd_t            cnd;
		logic [UpcW-1:0] target;
	} uword_t;

	// program addresses
	localparam logic [UpcW-1:0] UA_IDLE    = 4'd0;
	localparam logic [UpcW-1:0] UA_LOOP    = 4'd5;
	localparam logic [UpcW-1:0] UA_EXIT    = 4'd7;
	localparam logic [UpcW-1:0] UA_FIN_OK  = 4'd8;
	localparam logic [UpcW-1:0] UA_YADD    = 4'd9;
	localparam logic [UpcW-1:0] UA_FIN_OVF = 4'd11;
	localparam logic [UpcW-1:0] UA_FIN_INV = 4'd12;

	// control store
	function automatic uword_t ucode(input logic [UpcW-1:0] a);
		uword_t w;
		begin
			case (a)
				4'd0:    w = '{ACT_NOP,     CND_NO_START,  UA_IDLE};
				4'd1:    w = '{ACT_DIV,     CND_NEVER,     UA_IDLE};
				4'd2:    w = '{ACT_REM,     CND_NEVER,     UA_IDLE};
				4'd3:    w = '{ACT_NOP,     CND_INVALID,   UA_FIN_INV};
				4'd4:    w = '{ACT_NOP,     CND_YEAR_OP,   UA_YADD};
				4'd5:    w = '{ACT_NOP,     CND_LOOP_EXIT, UA_EXIT};
				4'd6:    w = '{ACT_MONTH,   CND_ALWAYS,    UA_LOOP};
				4'd7:    w = '{ACT_NOP,     CND_OVER,      UA_FIN_OVF};
				4'd8:    w = '{ACT_FIN_OK,  CND_ALWAYS,    UA_IDLE};
				4'd9:    w = '{ACT_YADD,    CND_YSUM_OVER, UA_FIN_OVF};
				4'd10:   w = '{ACT_NOP,     CND_ALWAYS,    UA_FIN_OK};
				4'd11:   w = '{ACT_FIN_OVF, CND_ALWAYS,    UA_IDLE};
				4'd12:   w = '{ACT_FIN_INV, CND_ALWAYS,    UA_IDLE};
				default: w = '{ACT_NOP,     CND_ALWAYS,    UA_IDLE};
			endcase
			return w;
		end
	endfunction

	// month length, zero for a month out of range
	function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m, input logic leap);
		logic [DayW-1:0] len;
		begin
			case (m)
				4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
				4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
				4'd2:                                        len = leap ? 5'd29 : 5'd28;
				default:                                     len = 5'd0;
			endcase
			return len;
		end
	endfunction

endpackage

FILE: design/gregorian_date_adder_core.sv
// gregorian date adder
// command channel: drive func, in_day, in_month, in_year and amount with start;
// the transfer happens at a clock edge where start is high and busy is low.
// func selects adding days, weeks, years or decades to the given date.
// result channel: out_day, out_month, out_year and status are valid for the
// single cycle in which done is high; the receiver cannot stall, so the
// result must be taken in that cycle. a new command may be sent in that cycle.
// a small microcoded sequencer runs each command, one control word a cycle.
// day and week adds split the year by 100, check the date, then run a
// two-word loop with one pass per month touched (the month ends crossed,
// plus one more when the count ends inside a month; none for a zero count),
// check for overflow and finish; year and decade adds split, check, add the
// years and finish; an invalid date finishes right after the check.
// one command at a time: busy stays high until the result is issued, so a
// new command is taken only once the last one is through.
// status 1 flags an invalid date, status 2 a result year above MAX_YEAR;
// both return the input date. reset puts the sequencer at idle with done low.
module gregorian_date_adder_core #(
	parameter int MAX_YEAR = 9999
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [gda_pkg::DayW-1:0]    in_day,
	input  logic [gda_pkg::MonW-1:0]    in_month,
	input  logic [gda_pkg::InYearW-1:0] in_year,
	input  logic [gda_pkg::AmtW-1:0]    amount,
	output logic                      done,
	output logic [gda_pkg::DayW-1:0]    out_day,
	output logic [gda_pkg::MonW-1:0]    out_month,
	output logic [gda_pkg::InYearW-1:0] out_year,
	output logic [gda_pkg::StatW-1:0]   status
);

	localparam logic [gda_pkg::YearW-1:0] MaxYr  = gda_pkg::YearW'(MAX_YEAR);
	localparam logic [gda_pkg::YSumW-1:0] MaxYrS = gda_pkg::YSumW'(MAX_YEAR);

	// sequencer
	logic [gda_pkg::UpcW-1:0] upc_q;
	gda_pkg::uword_t          uw;
	logic                     cond;
	logic                     accept;

	// command registers
	logic [1:0]                   func_q;
	logic [gda_pkg::DayW-1:0]     day0_q;
	logic [gda_pkg::MonW-1:0]     mon0_q;
	logic [gda_pkg::InYearW-1:0]  year0_q;
	logic [gda_pkg::AmtW-1:0]     amt_q;

	// working date
	logic [gda_pkg::DayW-1:0]     day_q;
	logic [gda_pkg::MonW-1:0]     mon_q;
	logic [gda_pkg::YearW-1:0]    year_q;
	logic [gda_pkg::CentW-1:0]    cent_q;
	logic [gda_pkg::RemW-1:0]     rem_q;
	logic [gda_pkg::LeftW-1:0]    left_q;

	// result registers
	logic                         done_q;
	logic [gda_pkg::DayW-1:0]     oday_q;
	logic [gda_pkg::MonW-1:0]     omon_q;
	logic [gda_pkg::InYearW-1:0]  oyear_q;
	logic [gda_pkg::StatW-1:0]    stat_q;

	// datapath terms
	logic [gda_pkg::ProdW-1:0]    prod;
	logic [gda_pkg::YearW-1:0]    cent_x100;
	logic                         leap;
	logic [gda_pkg::DayW-1:0]     mlen;
	logic [gda_pkg::DayW-1:0]     rest;
	logic                         invalid;
	logic                         over;
	logic [gda_pkg::YSumW-1:0]    ysum;
	logic [gda_pkg::YSumW-1:0]    yinc;

	assign uw     = gda_pkg::ucode(upc_q);
	assign busy   = (upc_q != gda_pkg::UA_IDLE);
	assign accept = start && !busy;

	// leap rule from the year split by 100
	assign leap = (rem_q[1:0] == 2'b00) && ((rem_q != '0) || (cent_q[1:0] == 2'b00));
	assign mlen = gda_pkg::month_len(mon_q, leap);
	assign rest = mlen - day_q;

	assign invalid = (mon_q == '0) || (mon_q > gda_pkg::MonDec) || (day_q == '0) ||
	                 (day_q > mlen);
	assign over    = (year_q > MaxYr);

	assign prod      = gda_pkg::ProdW'(year0_q) * gda_pkg::ProdW'(gda_pkg::Recip100);
	assign cent_x100 = gda_pkg::YearW'(cent_q) * gda_pkg::YearW'(100);

	// year and decade adds
	assign yinc = (func_q == gda_pkg::FUNC_DECADES) ?
	              gda_pkg::YSumW'(amt_q) * gda_pkg::YSumW'(10) : gda_pkg::YSumW'(amt_q);
	assign ysum = gda_pkg::YSumW'(year_q) + yinc;

	// branch condition select
	always_comb begin
		case (uw.cnd)
			gda_pkg::CND_NEVER:     cond = 1'b0;
			gda_pkg::CND_ALWAYS:    cond = 1'b1;
			gda_pkg::CND_NO_START:  cond = !start;
			gda_pkg::CND_INVALID:   cond = invalid;
			gda_pkg::CND_YEAR_OP:   cond = func_q[1];
			gda_pkg::CND_LOOP_EXIT: cond = over || (left_q == '0);
			gda_pkg::CND_OVER:      cond = over;
			gda_pkg::CND_YSUM_OVER: cond = (ysum > MaxYrS);
			default:                cond = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= gda_pkg::UA_IDLE;
		end else if (cond) begin
			upc_q <= uw.target;
		end else begin
			upc_q <= upc_q + 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (uw.act == gda_pkg::ACT_FIN_OK) || (uw.act == gda_pkg::ACT_FIN_INV) ||
			          (uw.act == gda_pkg::ACT_FIN_OVF);
		end
	end

	// command capture on transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			day0_q  <= in_day;
			mon0_q  <= in_month;
			year0_q <= in_year;
			amt_q   <= amount;
		end
	end

	// working datapath driven by the control word
	always_ff @(posedge clk) begin
		if (accept) begin
			day_q  <= in_day;
			mon_q  <= in_month;
			year_q <= gda_pkg::YearW'(in_year);
			left_q <= (func == gda_pkg::FUNC_WEEKS) ?
			          gda_pkg::LeftW'(amount) * gda_pkg::LeftW'(7) : gda_pkg::LeftW'(amount);
		end else begin
			case (uw.act)
				gda_pkg::ACT_DIV: begin
					cent_q <= gda_pkg::CentW'(prod[gda_pkg::ProdW-1:gda_pkg::RecipShift]);
				end
				gda_pkg::ACT_REM: begin
					rem_q <= gda_pkg::RemW'(year_q - cent_x100);
				end
				gda_pkg::ACT_MONTH: begin
					if (left_q <= gda_pkg::LeftW'(rest)) begin
						day_q  <= day_q + left_q[gda_pkg::DayW-1:0];
						left_q <= '0;
					end else begin
						left_q <= left_q - gda_pkg::LeftW'(rest) - 1'b1;
						day_q  <= gda_pkg::DayW'(1);
						if (mon_q == gda_pkg::MonDec) begin
							mon_q  <= gda_pkg::MonJan;
							year_q <= year_q + 1'b1;
							// keep the split by 100 in step with the year
							if (rem_q == gda_pkg::RemTop) begin
								rem_q  <= '0;
								cent_q <= cent_q + 1'b1;
							end else begin
								rem_q <= rem_q + 1'b1;
							end
						end else begin
							mon_q <= mon_q + 1'b1;
						end
					end
				end
				gda_pkg::ACT_YADD: begin
					year_q <= ysum[gda_pkg::YearW-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		case (uw.act)
			gda_pkg::ACT_FIN_OK: begin
				oday_q  <= day_q;
				omon_q  <= mon_q;
				oyear_q <= year_q[gda_pkg::InYearW-1:0];
				stat_q  <= gda_pkg::ST_OK;
			end
			gda_pkg::ACT_FIN_INV: begin
				oday_q  <= day0_q;
				omon_q  <= mon0_q;
				oyear_q <= year0_q;
				stat_q  <= gda_pkg::ST_INVALID;
			end
			gda_pkg::ACT_FIN_OVF: begin
				oday_q  <= day0_q;
				omon_q  <= mon0_q;
				oyear_q <= year0_q;
				stat_q  <= gda_pkg::ST_OVERFLOW;
			end
			default: begin
			end
		endcase
	end

	assign done      = done_q;
	assign out_day   = oday_q;
	assign out_month = omon_q;
	assign out_year  = oyear_q;
	assign status    = stat_q;

endmodule
